// ===== sv/assert_macros.svh =====
// Assertion helpers for the scroll offset easing controller.
// The clock and reset of the module that uses them are taken by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A property that must hold on every clock edge outside reset.
`define SOEC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");

// A condition in one cycle that must be followed by another in the next.
`define SOEC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`else

`define SOEC_ASSERT(lbl, prop)
`define SOEC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== sv/soec_pkg.sv =====
`default_nettype none

package soec_pkg;

  // Fixed-point format of times and speeds.
  localparam int FRAC_BITS = 16;

  // Field and state widths.
  localparam int OFS_W  = 40;
  localparam int DLY_W  = 22;
  localparam int ET_W   = 20;
  localparam int DT_W   = FRAC_BITS + 1;
  localparam int TGT_W  = 25;
  localparam int VH_W   = 13;
  localparam int CH_W   = 20;
  localparam int SD_W   = 21;
  localparam int LD_W   = 21;

  // Datapath widths: the speed error times five needs four more bits than
  // the speed, its magnitude one less than that.
  localparam int OPD_W  = OFS_W + 4;
  localparam int MAG_W  = OPD_W - 1;
  localparam int MHI_W  = MAG_W - FRAC_BITS;
  localparam int MA_W   = (MHI_W > FRAC_BITS) ? MHI_W : FRAC_BITS;
  localparam int PROD_W = MA_W + DT_W;
  localparam int ACC_W  = MAG_W + 1;
  localparam int SUM_W  = ACC_W + 2;

  // Register port.
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_TGT  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LOOP = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_VH   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CH   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SDLY = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LDLY = 3'd5;

  // Constants of the scroll behavior.
  localparam int DEFAULT_DT_I = ((16 << FRAC_BITS) + 500) / 1000;
  localparam logic [DT_W-1:0]  ONE_SEC    = DT_W'(1) << FRAC_BITS;
  localparam logic [DT_W-1:0]  DEFAULT_DT = DT_W'(DEFAULT_DT_I);
  localparam logic [TGT_W-1:0] DEF_TGT    = TGT_W'(60) << FRAC_BITS;
  localparam logic [VH_W-1:0]  DEF_VH     = VH_W'(1080);
  localparam logic [DLY_W-1:0] TIMER_MAX  = '1;

  typedef struct packed {
    logic [TGT_W-1:0] tgt;
    logic             loop_en;
    logic [VH_W-1:0]  vh;
    logic [CH_W-1:0]  ch;
    logic [SD_W-1:0]  sdly;
    logic [LD_W-1:0]  ldly;
  } cfg_t;

  // Datapath operations.
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
  localparam logic [OP_W-1:0] OP_BEGIN = 4'd1;
  localparam logic [OP_W-1:0] OP_SDLY  = 4'd2;
  localparam logic [OP_W-1:0] OP_LWAIT = 4'd3;
  localparam logic [OP_W-1:0] OP_DIFF  = 4'd4;
  localparam logic [OP_W-1:0] OP_X5    = 4'd5;
  localparam logic [OP_W-1:0] OP_MAG   = 4'd6;
  localparam logic [OP_W-1:0] OP_MHI   = 4'd7;
  localparam logic [OP_W-1:0] OP_MLO   = 4'd8;
  localparam logic [OP_W-1:0] OP_SUM   = 4'd9;
  localparam logic [OP_W-1:0] OP_UPDV  = 4'd10;
  localparam logic [OP_W-1:0] OP_UPDO  = 4'd11;
  localparam logic [OP_W-1:0] OP_END   = 4'd12;
  localparam logic [OP_W-1:0] OP_EMIT  = 4'd13;

  // Jump conditions.
  localparam int CND_W = 3;
  localparam logic [CND_W-1:0] C_NEVER    = 3'd0;
  localparam logic [CND_W-1:0] C_ALWAYS   = 3'd1;
  localparam logic [CND_W-1:0] C_IN_ACC   = 3'd2;
  localparam logic [CND_W-1:0] C_STOPPED  = 3'd3;
  localparam logic [CND_W-1:0] C_IN_SDLY  = 3'd4;
  localparam logic [CND_W-1:0] C_LOOPW    = 3'd5;
  localparam logic [CND_W-1:0] C_OUT_FREE = 3'd6;

  // Microprogram addresses.
  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] S_IDLE  = 5'd0;
  localparam logic [PC_W-1:0] S_CHECK = 5'd1;
  localparam logic [PC_W-1:0] S_SDLY  = 5'd2;
  localparam logic [PC_W-1:0] S_LWAIT = 5'd3;
  localparam logic [PC_W-1:0] S_DIFF  = 5'd4;
  localparam logic [PC_W-1:0] S_X5    = 5'd5;
  localparam logic [PC_W-1:0] S_MAGV  = 5'd6;
  localparam logic [PC_W-1:0] S_MHIV  = 5'd7;
  localparam logic [PC_W-1:0] S_MLOV  = 5'd8;
  localparam logic [PC_W-1:0] S_SUMV  = 5'd9;
  localparam logic [PC_W-1:0] S_UPDV  = 5'd10;
  localparam logic [PC_W-1:0] S_MAGO  = 5'd11;
  localparam logic [PC_W-1:0] S_MHIO  = 5'd12;
  localparam logic [PC_W-1:0] S_MLOO  = 5'd13;
  localparam logic [PC_W-1:0] S_SUMO  = 5'd14;
  localparam logic [PC_W-1:0] S_UPDO  = 5'd15;
  localparam logic [PC_W-1:0] S_END   = 5'd16;
  localparam logic [PC_W-1:0] S_EMIT  = 5'd17;

  // One control word: take an input word, datapath operation, jump
  // condition with its target, and whether to advance when not jumping.
  typedef struct packed {
    logic             take;
    logic [OP_W-1:0]  op;
    logic [CND_W-1:0] cnd;
    logic             adv;
    logic [PC_W-1:0]  tgt;
  } ucw_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic stopped;
    logic in_sdly;
    logic loop_wait;
    logic out_free;
  } dp_stat_t;

  function automatic ucw_t uw(input logic take, input logic [OP_W-1:0] op,
                              input logic [CND_W-1:0] cnd, input logic adv,
                              input logic [PC_W-1:0] tgt);
    ucw_t w;
    w.take = take;
    w.op   = op;
    w.cnd  = cnd;
    w.adv  = adv;
    w.tgt  = tgt;
    return w;
  endfunction

  // The microprogram for one frame tick.
  function automatic ucw_t ucode_rom(input logic [PC_W-1:0] addr);
    ucw_t w;
    case (addr)
      S_IDLE:  w = uw(1'b1, OP_NONE,  C_IN_ACC,   1'b0, S_CHECK);
      S_CHECK: w = uw(1'b0, OP_BEGIN, C_STOPPED,  1'b1, S_EMIT);
      S_SDLY:  w = uw(1'b0, OP_SDLY,  C_IN_SDLY,  1'b1, S_EMIT);
      S_LWAIT: w = uw(1'b0, OP_LWAIT, C_LOOPW,    1'b1, S_EMIT);
      S_DIFF:  w = uw(1'b0, OP_DIFF,  C_NEVER,    1'b1, S_IDLE);
      S_X5:    w = uw(1'b0, OP_X5,    C_NEVER,    1'b1, S_IDLE);
      S_MAGV:  w = uw(1'b0, OP_MAG,   C_NEVER,    1'b1, S_IDLE);
      S_MHIV:  w = uw(1'b0, OP_MHI,   C_NEVER,    1'b1, S_IDLE);
      S_MLOV:  w = uw(1'b0, OP_MLO,   C_NEVER,    1'b1, S_IDLE);
      S_SUMV:  w = uw(1'b0, OP_SUM,   C_NEVER,    1'b1, S_IDLE);
      S_UPDV:  w = uw(1'b0, OP_UPDV,  C_NEVER,    1'b1, S_IDLE);
      S_MAGO:  w = uw(1'b0, OP_MAG,   C_NEVER,    1'b1, S_IDLE);
      S_MHIO:  w = uw(1'b0, OP_MHI,   C_NEVER,    1'b1, S_IDLE);
      S_MLOO:  w = uw(1'b0, OP_MLO,   C_NEVER,    1'b1, S_IDLE);
      S_SUMO:  w = uw(1'b0, OP_SUM,   C_NEVER,    1'b1, S_IDLE);
      S_UPDO:  w = uw(1'b0, OP_UPDO,  C_NEVER,    1'b1, S_IDLE);
      S_END:   w = uw(1'b0, OP_END,   C_NEVER,    1'b1, S_IDLE);
      S_EMIT:  w = uw(1'b0, OP_EMIT,  C_OUT_FREE, 1'b0, S_IDLE);
      default: w = uw(1'b0, OP_NONE,  C_ALWAYS,   1'b0, S_IDLE);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== sv/soec_cfg.sv =====
`default_nettype none

module soec_cfg import soec_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg,
  output logic                   cfg_clr
);

  cfg_t cfg_r, cfg_nxt;
  logic wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;

  // Register writes; a write to a known register also restarts the scroll.
  always_comb begin
    cfg_nxt = cfg_r;
    cfg_clr = 1'b0;
    if (wr_en) begin
      cfg_clr = 1'b1;
      case (idx)
        REG_TGT:  cfg_nxt.tgt     = pwdata[TGT_W-1:0];
        REG_LOOP: cfg_nxt.loop_en = pwdata[0];
        REG_VH:   cfg_nxt.vh      = pwdata[VH_W-1:0];
        REG_CH:   cfg_nxt.ch      = pwdata[CH_W-1:0];
        REG_SDLY: cfg_nxt.sdly    = pwdata[SD_W-1:0];
        REG_LDLY: cfg_nxt.ldly    = pwdata[LD_W-1:0];
        default:  cfg_clr = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tgt     <= DEF_TGT;
      cfg_r.loop_en <= 1'b0;
      cfg_r.vh      <= DEF_VH;
      cfg_r.ch      <= '0;
      cfg_r.sdly    <= '0;
      cfg_r.ldly    <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back.
  always_comb begin
    case (idx)
      REG_TGT:  prdata = DATA_W'(cfg_r.tgt);
      REG_LOOP: prdata = DATA_W'(cfg_r.loop_en);
      REG_VH:   prdata = DATA_W'(cfg_r.vh);
      REG_CH:   prdata = DATA_W'(cfg_r.ch);
      REG_SDLY: prdata = DATA_W'(cfg_r.sdly);
      REG_LDLY: prdata = DATA_W'(cfg_r.ldly);
      default:  prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== sv/soec_seq.sv =====
`default_nettype none
`include "assert_macros.svh"

module soec_seq import soec_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  dp_stat_t      stat,
  output ucw_t          cw,
  output logic          in_ready
);

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic taken;

  assign cw       = ucode_rom(pc_r);
  assign in_ready = cw.take;

  // Jump condition of the current step.
  always_comb begin
    case (cw.cnd)
      C_NEVER:    taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_IN_ACC:   taken = in_valid && cw.take;
      C_STOPPED:  taken = stat.stopped;
      C_IN_SDLY:  taken = stat.in_sdly;
      C_LOOPW:    taken = stat.loop_wait;
      C_OUT_FREE: taken = stat.out_free;
      default:    taken = 1'b0;
    endcase
  end

  // Step counter: jump, advance, or hold.
  assign pc_nxt = taken ? cw.tgt : (pc_r + PC_W'(cw.adv));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  `SOEC_ASSERT(a_ready_only_idle, !in_ready || (pc_r == S_IDLE))
  `SOEC_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, pc_r == S_CHECK)
  `SOEC_ASSERT(a_pc_in_program, pc_r <= S_EMIT)

endmodule

`default_nettype wire

// ===== sv/soec_dp.sv =====
`default_nettype none
`include "assert_macros.svh"

module soec_dp import soec_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  ucw_t                         cw,
  input  cfg_t                         cfg,
  input  wire logic                    cfg_clr,
  input  wire logic                    in_valid,
  input  wire logic [ET_W-1:0]         in_elapsed_time,
  input  wire logic                    out_ready,
  output dp_stat_t                     stat,
  output logic                         out_valid,
  output logic signed [OFS_W-1:0]      out_offset,
  output logic                         out_active,
  output logic                         out_pausing
);

  localparam logic signed [SUM_W-1:0] SAT_HI =
    $signed({{(SUM_W-OFS_W+1){1'b0}}, {(OFS_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] SAT_LO =
    $signed({{(SUM_W-OFS_W+1){1'b1}}, {(OFS_W-1){1'b0}}});
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

  function automatic logic signed [OFS_W-1:0] sat_ofs(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] s;
    s = v;
    if (v > SAT_HI) begin
      s = SAT_HI;
    end else if (v < SAT_LO) begin
      s = SAT_LO;
    end
    return s[OFS_W-1:0];
  endfunction

  // Scroll state.
  logic signed [OFS_W-1:0] offset_r, offset_nxt, speed_r, speed_nxt;
  logic [DLY_W-1:0] delay_r, delay_nxt;
  logic running_r, running_nxt, begun_r, begun_nxt, loop_wait_r, loop_wait_nxt;

  // Working registers of the tick.
  logic [DT_W-1:0] dt_r, dt_nxt;
  logic signed [OPD_W-1:0] opnd_r, opnd_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic neg_r, neg_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [DT_W-1:0] lo_r, lo_nxt;

  // Result word.
  logic out_valid_r, out_valid_nxt;
  logic signed [OFS_W-1:0] out_offset_r;
  logic out_active_r, out_pausing_r;

  logic in_acc, bad_dt, in_sdly, out_free, past_end, emit;
  logic [VH_W-1:0] vh_eff;
  logic [TGT_W-1:0] tgt_eff;
  logic signed [OFS_W-1:0] vh_fx, restart_ofs, ch_fx;
  logic [DLY_W:0] tsum;
  logic [DLY_W-1:0] tadd;
  logic [MA_W-1:0] mul_a;
  logic [PROD_W-1:0] mul_p, lo_sum;
  logic signed [OPD_W-1:0] opnd_abs;
  logic signed [SUM_W-1:0] acc_ext, sacc, spd_sum, ofs_sum;
  logic signed [OFS_W-1:0] spd_sat;

  assign in_acc   = in_valid && cw.take;
  assign out_free = !out_valid_r || out_ready;
  assign emit     = (cw.op == OP_EMIT) && out_free;

  // Frame time: a zero or over-long time falls back to the default.
  assign bad_dt = (in_elapsed_time == '0) || (in_elapsed_time > ET_W'(ONE_SEC));
  assign dt_nxt = in_acc ? (bad_dt ? DEFAULT_DT : in_elapsed_time[DT_W-1:0]) : dt_r;

  // Effective configuration values and fixed-point positions.
  assign vh_eff      = (cfg.vh == '0) ? DEF_VH : cfg.vh;
  assign tgt_eff     = (cfg.tgt == '0) ? DEF_TGT : cfg.tgt;
  assign vh_fx       = $signed(OFS_W'(vh_eff) << FRAC_BITS);
  assign restart_ofs = -vh_fx;
  assign ch_fx       = $signed(OFS_W'(cfg.ch) << FRAC_BITS);
  assign past_end    = offset_r > ch_fx;

  // Saturating delay timer.
  assign tsum    = {1'b0, delay_r} + (DLY_W+1)'(dt_r);
  assign tadd    = tsum[DLY_W] ? TIMER_MAX : tsum[DLY_W-1:0];
  assign in_sdly = (cfg.sdly != '0) && (delay_r < DLY_W'(cfg.sdly));

  // Shared multiplier: whole part or fraction of the magnitude times dt.
  assign mul_a  = (cw.op == OP_MHI) ? MA_W'(mag_r[MAG_W-1:FRAC_BITS])
                                    : MA_W'(mag_r[FRAC_BITS-1:0]);
  assign mul_p  = PROD_W'(mul_a) * PROD_W'(dt_r);
  assign lo_sum = mul_p + HALF;

  // Magnitude and signed product paths.
  assign opnd_abs = opnd_r[OPD_W-1] ? -opnd_r : opnd_r;
  assign acc_ext  = $signed({2'b00, acc_r});
  assign sacc     = neg_r ? -acc_ext : acc_ext;
  assign spd_sum  = $signed({{(SUM_W-OFS_W){speed_r[OFS_W-1]}}, speed_r}) + sacc;
  assign ofs_sum  = $signed({{(SUM_W-OFS_W){offset_r[OFS_W-1]}}, offset_r}) + sacc;
  assign spd_sat  = sat_ofs(spd_sum);

  // Step operations.
  always_comb begin
    offset_nxt    = offset_r;
    speed_nxt     = speed_r;
    delay_nxt     = delay_r;
    running_nxt   = running_r;
    begun_nxt     = begun_r;
    loop_wait_nxt = loop_wait_r;
    opnd_nxt      = opnd_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    lo_nxt        = lo_r;
    case (cw.op)
      OP_BEGIN: begin
        if (running_r && !begun_r) begin
          offset_nxt = restart_ofs;
          delay_nxt  = '0;
          begun_nxt  = 1'b1;
        end
      end
      OP_SDLY: begin
        if (in_sdly) begin
          delay_nxt = tadd;
        end
      end
      OP_LWAIT: begin
        if (loop_wait_r) begin
          if (tadd >= DLY_W'(cfg.ldly)) begin
            loop_wait_nxt = 1'b0;
            offset_nxt    = restart_ofs;
            speed_nxt     = '0;
            delay_nxt     = DLY_W'(cfg.sdly);
          end else begin
            delay_nxt = tadd;
          end
        end
      end
      OP_DIFF: begin
        opnd_nxt = $signed({{(OPD_W-TGT_W){1'b0}}, tgt_eff})
                 - $signed({{(OPD_W-OFS_W){speed_r[OFS_W-1]}}, speed_r});
      end
      OP_X5: begin
        opnd_nxt = opnd_r + (opnd_r <<< 2);
      end
      OP_MAG: begin
        neg_nxt = opnd_r[OPD_W-1];
        mag_nxt = opnd_abs[MAG_W-1:0];
      end
      OP_MHI: begin
        acc_nxt = mul_p[ACC_W-1:0];
      end
      OP_MLO: begin
        lo_nxt = lo_sum[FRAC_BITS +: DT_W];
      end
      OP_SUM: begin
        acc_nxt = acc_r + ACC_W'(lo_r);
      end
      OP_UPDV: begin
        // New speed, also loaded as the next operand.
        speed_nxt = spd_sat;
        opnd_nxt  = $signed({{(OPD_W-OFS_W){spd_sat[OFS_W-1]}}, spd_sat});
      end
      OP_UPDO: begin
        offset_nxt = sat_ofs(ofs_sum);
      end
      OP_END: begin
        if (past_end) begin
          if (cfg.loop_en) begin
            if (cfg.ldly != '0) begin
              loop_wait_nxt = 1'b1;
              delay_nxt     = '0;
            end else begin
              offset_nxt = restart_ofs;
              speed_nxt  = '0;
            end
          end else begin
            running_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    // A register write restarts the scroll state.
    if (cfg_clr) begin
      offset_nxt    = '0;
      speed_nxt     = '0;
      delay_nxt     = '0;
      running_nxt   = 1'b1;
      begun_nxt     = 1'b0;
      loop_wait_nxt = 1'b0;
    end
  end

  // Output word handshake.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= '0;
      speed_r     <= '0;
      delay_r     <= '0;
      running_r   <= 1'b1;
      begun_r     <= 1'b0;
      loop_wait_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      offset_r    <= offset_nxt;
      speed_r     <= speed_nxt;
      delay_r     <= delay_nxt;
      running_r   <= running_nxt;
      begun_r     <= begun_nxt;
      loop_wait_r <= loop_wait_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    dt_r   <= dt_nxt;
    opnd_r <= opnd_nxt;
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    acc_r  <= acc_nxt;
    lo_r   <= lo_nxt;
    if (emit) begin
      out_offset_r  <= offset_r;
      out_active_r  <= running_r;
      out_pausing_r <= running_r && (loop_wait_r || in_sdly);
    end
  end

  assign stat.stopped   = !running_r;
  assign stat.in_sdly   = in_sdly;
  assign stat.loop_wait = loop_wait_r;
  assign stat.out_free  = out_free;

  assign out_valid   = out_valid_r;
  assign out_offset  = out_offset_r;
  assign out_active  = out_active_r;
  assign out_pausing = out_pausing_r;

  `SOEC_ASSERT_NEXT(a_clr_restarts, cfg_clr, running_r && !begun_r && !loop_wait_r)
  `SOEC_ASSERT(a_wait_implies_run, !loop_wait_r || running_r)
  `SOEC_ASSERT_NEXT(a_emit_shows_word, emit, out_valid_r)

endmodule

`default_nettype wire

// ===== sv/scroll_offset_easing_controller.sv =====
// Each frame tick runs the microprogram up to its emit step, which registers the result word;
// a stopped scroll jumps there from the check step, the start and loop delays from their timer
// steps. A new tick is taken only at the idle step, after the emit step of the previous one;
// each eased tick uses the single shared 27x17 multiplier four times. A waiting result holds the
// sequencer at its emit step. Reset: rst_n is synchronous, active low; it loads the register
// reset values and restarts the scroll state, which each write to a known register restarts as well.
`default_nettype none

module scroll_offset_easing_controller import soec_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [ET_W-1:0]     in_elapsed_time,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [OFS_W-1:0]  out_offset,
  output logic                     out_active,
  output logic                     out_pausing,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [DATA_W-1:0]   pwdata,
  output logic      [DATA_W-1:0]   prdata,
  output logic                     pready
);

  cfg_t     cfg;
  logic     cfg_clr;
  ucw_t     cw;
  dp_stat_t stat;

  // Register file.
  soec_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .cfg_clr (cfg_clr)
  );

  // Microcode sequencer.
  soec_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .cw       (cw),
    .in_ready (in_ready)
  );

  // Datapath and result word.
  soec_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cw              (cw),
    .cfg             (cfg),
    .cfg_clr         (cfg_clr),
    .in_valid        (in_valid),
    .in_elapsed_time (in_elapsed_time),
    .out_ready       (out_ready),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_offset      (out_offset),
    .out_active      (out_active),
    .out_pausing     (out_pausing)
  );

endmodule

`default_nettype wire

// ===== sim/scroll_offset_easing_checker.sv =====
`timescale 1ns / 1ps

// Watches the tick, result and register channels of the scroll controller.
// It keeps its own copy of the scroll state, predicts one result word per
// accepted tick and compares every accepted result word with the oldest
// prediction.
module scroll_offset_easing_checker import soec_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [ET_W-1:0]         in_elapsed_time,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [OFS_W-1:0] out_offset,
  input  logic                    out_active,
  input  logic                    out_pausing,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic                    pready,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output int                      fail_count,
  output int                      pending
);

  localparam longint unsigned FRAME_SEC     = 64'd1 << FRAC_BITS;
  localparam longint unsigned DEFAULT_FRAME = ((64'd16 << FRAC_BITS) + 500) / 1000;
  localparam longint unsigned TIMER_LIMIT   = (64'd1 << DLY_W) - 1;
  localparam longint          DEFAULT_SPEED = longint'(60) <<< FRAC_BITS;
  localparam longint          VIEW_DEFAULT  = 1080;
  localparam longint          POS_MAX       = (longint'(1) <<< (OFS_W - 1)) - 1;
  localparam longint          POS_MIN       = -POS_MAX - 1;

  typedef struct {
    logic signed [OFS_W-1:0] offset;
    logic                    active;
    logic                    pausing;
  } scroll_word_t;

  // Register copy.
  logic [TGT_W-1:0] tgt_speed;
  logic             loop_en;
  logic [VH_W-1:0]  view_h;
  logic [CH_W-1:0]  content_h;
  logic [SD_W-1:0]  start_dly;
  logic [LD_W-1:0]  loop_dly;

  // Scroll state copy.
  longint           pos;
  longint           vel;
  logic [DLY_W-1:0] dly_cnt;
  logic             running;
  logic             begun;
  logic             loop_wait;

  scroll_word_t expected_words[$];

  function automatic longint clamp40(input longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  // Product with the frame time, rounded to nearest with halves away from zero.
  function automatic longint scale_by_dt(input longint v, input longint unsigned dt);
    longint unsigned mag;
    longint unsigned whole;
    longint unsigned frac;
    longint unsigned res;
    mag   = (v < 0) ? longint'(-v) : longint'(v);
    whole = mag >> FRAC_BITS;
    frac  = mag & (FRAME_SEC - 1);
    res   = whole * dt + ((frac * dt + (FRAME_SEC >> 1)) >> FRAC_BITS);
    return (v < 0) ? -longint'(res) : longint'(res);
  endfunction

  function automatic logic [DLY_W-1:0] timer_step(input logic [DLY_W-1:0] t,
                                                   input longint unsigned dt);
    longint unsigned s;
    s = 64'(t) + dt;
    if (s > TIMER_LIMIT) s = TIMER_LIMIT;
    return s[DLY_W-1:0];
  endfunction

  function automatic longint restart_pos();
    longint h;
    h = (view_h != 0) ? longint'(view_h) : VIEW_DEFAULT;
    return -(h <<< FRAC_BITS);
  endfunction

  function automatic void clear_scroll();
    pos       = 0;
    vel       = 0;
    dly_cnt   = '0;
    running   = 1'b1;
    begun     = 1'b0;
    loop_wait = 1'b0;
  endfunction

  // A write to a known register restarts the scroll; other addresses are ignored.
  function automatic void apply_write(input logic [REG_IDX_W-1:0] idx,
                                      input logic [DATA_W-1:0] val);
    case (idx)
      REG_TGT:  tgt_speed = val[TGT_W-1:0];
      REG_LOOP: loop_en   = val[0];
      REG_VH:   view_h    = val[VH_W-1:0];
      REG_CH:   content_h = val[CH_W-1:0];
      REG_SDLY: start_dly = val[SD_W-1:0];
      REG_LDLY: loop_dly  = val[LD_W-1:0];
      default:  return;
    endcase
    clear_scroll();
  endfunction

  // One frame tick: delays, easing of the speed, offset integration, end handling.
  function automatic scroll_word_t advance_frame(input logic [ET_W-1:0] et);
    longint unsigned dt;
    longint          goal;
    longint          err5;
    scroll_word_t    w;
    dt = 64'(et);
    if (dt == 0 || dt > FRAME_SEC) dt = DEFAULT_FRAME;
    if (running) begin
      if (!begun) begin
        pos     = restart_pos();
        dly_cnt = '0;
        begun   = 1'b1;
      end
      if (start_dly != 0 && dly_cnt < DLY_W'(start_dly)) begin
        dly_cnt = timer_step(dly_cnt, dt);
      end else if (loop_wait) begin
        dly_cnt = timer_step(dly_cnt, dt);
        if (dly_cnt >= DLY_W'(loop_dly)) begin
          loop_wait = 1'b0;
          pos       = restart_pos();
          vel       = 0;
          dly_cnt   = DLY_W'(start_dly);
        end
      end else begin
        goal = (tgt_speed != 0) ? longint'(tgt_speed) : DEFAULT_SPEED;
        err5 = (goal - vel) * 5;
        vel  = clamp40(vel + scale_by_dt(err5, dt));
        pos  = clamp40(pos + scale_by_dt(vel, dt));
        if (pos > (longint'(content_h) <<< FRAC_BITS)) begin
          if (loop_en) begin
            if (loop_dly != 0) begin
              loop_wait = 1'b1;
              dly_cnt   = '0;
            end else begin
              pos = restart_pos();
              vel = 0;
            end
          end else begin
            running = 1'b0;
          end
        end
      end
    end
    w.offset  = pos[OFS_W-1:0];
    w.active  = running;
    w.pausing = running && (loop_wait || (start_dly != 0 && dly_cnt < DLY_W'(start_dly)));
    return w;
  endfunction

  // Result words are checked before the tick of the same edge is predicted.
  always @(posedge clk) begin
    scroll_word_t want;
    if (!rst_n) begin
      tgt_speed = TGT_W'(60) << FRAC_BITS;
      loop_en   = 1'b0;
      view_h    = VH_W'(1080);
      content_h = '0;
      start_dly = '0;
      loop_dly  = '0;
      clear_scroll();
      expected_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: offset %0d", out_offset);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (out_offset !== want.offset) begin
            $error("offset: expected %0d, actual %0d", want.offset, out_offset);
            fail_count++;
          end
          if (out_active !== want.active) begin
            $error("active: expected %0b, actual %0b", want.active, out_active);
            fail_count++;
          end
          if (out_pausing !== want.pausing) begin
            $error("pausing: expected %0b, actual %0b", want.pausing, out_pausing);
            fail_count++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        apply_write(paddr[ADDR_W-1:2], pwdata);
      end
      if (in_valid && in_ready) begin
        expected_words.push_back(advance_frame(in_elapsed_time));
      end
    end
    pending = expected_words.size();
  end

endmodule

// ===== sim/tb_scroll_offset_easing_controller.sv =====
`timescale 1ns / 1ps

module tb_scroll_offset_easing_controller import soec_pkg::*; ;

  localparam int RANDOM_ITEMS = 1350;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_WAIT  = 20;
  localparam int DRAIN_WAIT   = 40;

  // Addresses past the last register; writes there must leave the state alone.
  localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam logic [ET_W-1:0] ET_ONE_SEC = ET_W'(65536);

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [ET_W-1:0]         in_elapsed_time = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [OFS_W-1:0] out_offset;
  logic                    out_active;
  logic                    out_pausing;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [DATA_W-1:0]       pwdata = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;

  int fail_count;
  int pending;
  int in_gap_pct = 22;
  int out_gap_pct = 45;
  int hold_requests = 0;
  int cycle_count = 0;

  always #5 clk = ~clk;

  scroll_offset_easing_controller dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_elapsed_time (in_elapsed_time),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_offset      (out_offset),
    .out_active      (out_active),
    .out_pausing     (out_pausing),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  scroll_offset_easing_checker offset_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_elapsed_time (in_elapsed_time),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_offset      (out_offset),
    .out_active      (out_active),
    .out_pausing     (out_pausing),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // Offer one tick word, with random idle cycles ahead of it, and wait until taken.
  task automatic send_frame(input logic [ET_W-1:0] et);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_elapsed_time = et;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering and let every expected result word drain out.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  // Setup cycle, then access cycle; the write lands when pready is seen high.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Frame times: mostly near one video frame, some long, some out of range.
  function automatic logic [ET_W-1:0] pick_frame_time();
    int r;
    r = $urandom_range(99);
    if (r < 45) return ET_W'($urandom_range(900, 1200));
    if (r < 70) return ET_W'($urandom_range(1, 65536));
    if (r < 85) return ET_W'($urandom_range(32768, 65536));
    if (r < 92) return ($urandom_range(1) != 0) ? ET_ONE_SEC : '0;
    return ET_W'($urandom_range(65537, 1048575));
  endfunction

  // Program all six registers for one random phase.
  task automatic program_random_setting();
    logic [DATA_W-1:0] tgt;
    logic [DATA_W-1:0] lp;
    logic [DATA_W-1:0] vh;
    logic [DATA_W-1:0] ch;
    logic [DATA_W-1:0] sd;
    logic [DATA_W-1:0] ld;
    case ($urandom_range(3))
      0: begin
        // Short scroll that ends within a few dozen ticks.
        tgt = $urandom_range(655360, 32768000);
        lp  = $urandom_range(1);
        vh  = $urandom_range(1, 64);
        ch  = $urandom_range(0, 64);
        sd  = ($urandom_range(2) == 0) ? 0 : $urandom_range(0, 196608);
        ld  = ($urandom_range(2) == 0) ? 0 : $urandom_range(0, 196608);
      end
      1: begin
        // Corners of every register, the zero defaults included.
        case ($urandom_range(2))
          0: tgt = 0;
          1: tgt = 655360;
          default: tgt = 32768000;
        endcase
        case ($urandom_range(2))
          0: vh = 0;
          1: vh = 1;
          default: vh = 4096;
        endcase
        lp = $urandom_range(1);
        ch = ($urandom_range(1) != 0) ? 0 : 1048575;
        sd = ($urandom_range(1) != 0) ? 0 : 1966080;
        ld = ($urandom_range(1) != 0) ? 0 : 1966080;
      end
      2: begin
        // Raw words, upper bits beyond the register's width included for all but the content height.
        tgt = $urandom();
        lp  = $urandom();
        vh  = $urandom();
        ch  = $urandom() & 32'h0000_03ff;
        sd  = $urandom() & 32'hffe3_ffff;
        ld  = $urandom() & 32'hffe3_ffff;
      end
      default: begin
        tgt = $urandom_range(655360, 32768000);
        lp  = $urandom_range(1);
        vh  = $urandom_range(1, 4096);
        ch  = $urandom_range(0, 2000);
        sd  = ($urandom_range(3) == 0) ? $urandom_range(0, 1966080) : 0;
        ld  = ($urandom_range(3) == 0) ? $urandom_range(0, 1966080) : $urandom_range(0, 65536);
      end
    endcase
    write_reg(REG_TGT, tgt);
    write_reg(REG_LOOP, lp);
    write_reg(REG_VH, vh);
    write_reg(REG_CH, ch);
    write_reg(REG_SDLY, sd);
    write_reg(REG_LDLY, ld);
  endtask

  // Result receiver: random stalls, or a long hold-off when one is asked for.
  initial begin
    int held;
    int holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        @(negedge clk);
        out_ready = 1'b0;
        for (held = 1; held < HOLD_CYCLES; held++) @(negedge clk);
        holds_done++;
      end else begin
        @(negedge clk);
        out_ready = ($urandom_range(99) >= out_gap_pct);
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int random_sent;
    int phase_len;
    int spare_at;
    int k;
    bit hold_issued;
    random_sent = 0;
    hold_issued = 1'b0;

    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset values: out-of-range frame times, one second, the smallest time.
    send_frame('0);
    send_frame(ET_W'(65537));
    send_frame('1);
    send_frame(ET_ONE_SEC);
    send_frame(ET_W'(1));
    send_frame(ET_W'(1049));

    // Zero target speed and zero view height fall back to their defaults.
    wait_idle();
    write_reg(REG_TGT, 0);
    write_reg(REG_VH, 0);
    repeat (3) send_frame(ET_ONE_SEC);

    // Fastest scroll over a tiny view: it ends at once and then stays stopped.
    wait_idle();
    write_reg(REG_TGT, 32768000);
    write_reg(REG_VH, 1);
    write_reg(REG_CH, 0);
    write_reg(REG_LOOP, 0);
    repeat (4) send_frame(ET_ONE_SEC);

    // Looping with no pause restarts right away.
    wait_idle();
    write_reg(REG_LOOP, 1);
    write_reg(REG_LDLY, 0);
    repeat (4) send_frame(ET_ONE_SEC);

    // Start delay, then a loop delay, then the restart after it.
    wait_idle();
    write_reg(REG_SDLY, 131072);
    write_reg(REG_LDLY, 196608);
    repeat (6) send_frame(ET_ONE_SEC);

    // A write to an unused address keeps the scroll where it is.
    wait_idle();
    write_reg(REG_SPARE_A, $urandom());
    send_frame(ET_ONE_SEC);
    send_frame(ET_ONE_SEC);

    // Random phases, each under a fresh register setting.
    while (random_sent < RANDOM_ITEMS) begin
      wait_idle();
      if (random_sent < RANDOM_ITEMS / 3) begin
        in_gap_pct  = 22;
        out_gap_pct = 45;
      end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
        in_gap_pct  = 45;
        out_gap_pct = 22;
      end else begin
        in_gap_pct  = 0;
        out_gap_pct = 0;
      end
      program_random_setting();
      // Once, with the sender at full rate, the receiver holds off for a long stretch.
      if (in_gap_pct == 0 && !hold_issued) begin
        hold_requests++;
        hold_issued = 1'b1;
      end
      phase_len = $urandom_range(20, 70);
      spare_at  = ($urandom_range(3) == 0) ? phase_len / 2 : -1;
      for (k = 0; k < phase_len; k++) begin
        if (k == spare_at) begin
          wait_idle();
          write_reg(($urandom_range(1) != 0) ? REG_SPARE_A : REG_SPARE_B, $urandom());
        end
        send_frame(pick_frame_time());
        random_sent++;
      end
    end

    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
